// ===== rtl/core/gpse_pkg.sv =====
package gpse_pkg;

   // Field widths
   localparam int PHASE_W   = 3;
   localparam int HEIGHT_W  = 16;
   localparam int TIME_W    = 32;
   localparam int SPEED_W   = 32;
   localparam int GAIN_W    = 16;
   localparam int TIMEOUT_W = 8;
   localparam int PERIOD_W  = TIME_W + 1;
   localparam int SUM_W     = HEIGHT_W + 1;
   localparam int PROD_W    = 2 * SUM_W;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_GAIN    = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STILL_TIMEOUT = 4'd1;
   localparam logic [GAIN_W-1:0]     GAIN_RESET        = 16'd256;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET     = 8'd6;

   // Gait phase codes
   localparam logic [PHASE_W-1:0] PH_REST    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_OFF     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SWING   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CONTACT = 3'd3;

   // Latch flag bit positions
   localparam int FLAG_LEFT_OFF      = 0;
   localparam int FLAG_LEFT_CONTACT  = 1;
   localparam int FLAG_RIGHT_OFF     = 2;
   localparam int FLAG_RIGHT_CONTACT = 3;

   // Divider: denominator is period plus one second, numerator gain*peak*512 plus half
   localparam int DEN_W    = PERIOD_W + 1;
   localparam int DIV_BITS = 41;
   localparam int CNT_W    = $clog2(DIV_BITS + 1);
   localparam logic [DEN_W-1:0] ONE_SECOND = 34'd65536;
   localparam logic [TIMEOUT_W-1:0] STILL_MAX = 8'hFF;
   localparam logic [PROD_W-1:0] ROUND_HALF = 34'd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_DIV_SETUP,
      ST_DIV,
      ST_FIN
   } gpse_state_type;

endpackage

// ===== rtl/core/gpse_if.sv =====
interface gpse_req_if import gpse_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PHASE_W-1:0]         left_phase;
   logic [PHASE_W-1:0]         right_phase;
   logic signed [HEIGHT_W-1:0] left_height;
   logic signed [HEIGHT_W-1:0] right_height;
   logic [TIME_W-1:0]          left_time;
   logic [TIME_W-1:0]          right_time;

   modport source (output valid, left_phase, right_phase, left_height, right_height,
                   left_time, right_time, input ready);
   modport sink   (input valid, left_phase, right_phase, left_height, right_height,
                   left_time, right_time, output ready);
endinterface

interface gpse_rsp_if import gpse_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] speed;

   modport source (output valid, speed, input ready);
   modport sink   (input valid, speed, output ready);
endinterface

interface gpse_csr_if import gpse_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/gait_period_speed_estimator.sv =====
// An accepted beat runs ST_MUL, then goes straight to ST_FIN when stationary or on a
// negative peak, via ST_ROUND at startup (peak zero), or via ST_DIV_SETUP and the
// 41-step restoring divider otherwise. Only ST_IDLE takes a new beat; ST_FIN stalls
// until the output register is free, where a result waits while the next beat runs.
// Reset (synchronous, active high) clears all gait state, loads gain 256 and timeout 6.
module gait_period_speed_estimator import gpse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gpse_req_if.sink    req_bus,
   gpse_rsp_if.source  rsp_bus,
   gpse_csr_if.sink    csr_bus
);

   gpse_state_type state_ff, state_in;

   // Configuration
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   // Gait state
   logic [PHASE_W-1:0]         prev_lp_ff, prev_lp_in;
   logic [PHASE_W-1:0]         prev_rp_ff, prev_rp_in;
   logic [TIME_W-1:0]          lot_ff, lot_in, lct_ff, lct_in;
   logic [TIME_W-1:0]          rot_ff, rot_in, rct_ff, rct_in;
   logic [3:0]                 flags_ff, flags_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic signed [HEIGHT_W-1:0] peak_ff, peak_in;
   logic [TIMEOUT_W-1:0]       still_ff, still_in;
   logic signed [SPEED_W-1:0]  held_ff, held_in;
   logic                       moving_ff, moving_in;

   // Datapath of the shared multiply / divide unit
   logic signed [SUM_W-1:0]  hsum_ff, hsum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_BITS-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;

   logic accept;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.speed = rsp_speed_ff;

   always_comb begin
      logic                       l_off, l_con, r_off, r_con, moving, qbit;
      logic [TIME_W-1:0]          lot_v, lct_v, rot_v, rct_v, ldiff, rdiff;
      logic [3:0]                 flags_v;
      logic [PERIOD_W-1:0]        period_v;
      logic signed [HEIGHT_W-1:0] peak_v;
      logic signed [SUM_W-1:0]    mul_a, mul_b;
      logic signed [PROD_W-1:0]   rounded;
      logic [DEN_W-1:0]           den_calc;
      logic [DEN_W:0]             trial, trial_diff;

      state_in     = state_ff;
      gain_in      = gain_ff;
      timeout_in   = timeout_ff;
      prev_lp_in   = prev_lp_ff;
      prev_rp_in   = prev_rp_ff;
      lot_in       = lot_ff;
      lct_in       = lct_ff;
      rot_in       = rot_ff;
      rct_in       = rct_ff;
      flags_in     = flags_ff;
      period_in    = period_ff;
      peak_in      = peak_ff;
      still_in     = still_ff;
      held_in      = held_ff;
      moving_in    = moving_ff;
      hsum_in      = hsum_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_speed_in = rsp_speed_ff;
      peak_v       = peak_ff;

      // Transition detect and latch update for the beat on the input
      l_off = (prev_lp_ff == PH_REST)  && (req_bus.left_phase  == PH_OFF);
      l_con = (prev_lp_ff == PH_SWING) && (req_bus.left_phase  == PH_CONTACT);
      r_off = (prev_rp_ff == PH_REST)  && (req_bus.right_phase == PH_OFF);
      r_con = (prev_rp_ff == PH_SWING) && (req_bus.right_phase == PH_CONTACT);
      moving = (req_bus.left_phase != PH_REST) || (req_bus.right_phase != PH_REST);

      flags_v  = flags_ff;
      period_v = period_ff;
      lot_v    = l_off ? req_bus.left_time  : lot_ff;
      lct_v    = l_con ? req_bus.left_time  : lct_ff;
      rot_v    = r_off ? req_bus.right_time : rot_ff;
      rct_v    = r_con ? req_bus.right_time : rct_ff;
      ldiff    = lct_v - lot_v;
      rdiff    = rct_v - rot_v;

      // Left foot first, right foot may override the period on the same beat
      if (l_off) flags_v[FLAG_LEFT_OFF] = 1'b1;
      if (l_con) flags_v[FLAG_LEFT_CONTACT] = 1'b1;
      if (flags_v[FLAG_LEFT_OFF] && flags_v[FLAG_LEFT_CONTACT]) begin
         flags_v[FLAG_LEFT_OFF]     = 1'b0;
         flags_v[FLAG_LEFT_CONTACT] = 1'b0;
         if (lct_v > lot_v) period_v = {ldiff, 1'b0};
      end
      if (r_off) flags_v[FLAG_RIGHT_OFF] = 1'b1;
      if (r_con) flags_v[FLAG_RIGHT_CONTACT] = 1'b1;
      if (flags_v[FLAG_RIGHT_OFF] && flags_v[FLAG_RIGHT_CONTACT]) begin
         flags_v[FLAG_RIGHT_OFF]     = 1'b0;
         flags_v[FLAG_RIGHT_CONTACT] = 1'b0;
         if (rct_v > rot_v) period_v = {rdiff, 1'b0};
      end

      // Shared multiplier: gain times height sum at startup, else gain times peak
      mul_a    = $signed({1'b0, gain_ff});
      mul_b    = (peak_ff == '0) ? hsum_ff : SUM_W'(peak_ff);
      rounded  = prod_ff + $signed(ROUND_HALF);
      den_calc = {1'b0, period_ff} + ONE_SECOND;
      trial      = {rem_ff, num_ff[DIV_BITS-1]};
      trial_diff = trial - {1'b0, den_ff};
      qbit       = !trial_diff[DEN_W];

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lot_in    = lot_v;
               lct_in    = lct_v;
               rot_in    = rot_v;
               rct_in    = rct_v;
               flags_in  = flags_v;
               period_in = period_v;
               if (moving) begin
                  // Latch the peak on contact; right wins a tie
                  still_in = '0;
                  if (l_con) peak_v = req_bus.left_height;
                  if (r_con) peak_v = req_bus.right_height;
               end else if (still_ff > timeout_ff) begin
                  // Timeout: clear speed, peak and period
                  held_in   = '0;
                  peak_v    = '0;
                  period_in = '0;
               end else if (still_ff != STILL_MAX) begin
                  still_in = still_ff + 1'b1;
               end
               peak_in    = peak_v;
               moving_in  = moving;
               prev_lp_in = req_bus.left_phase;
               prev_rp_in = req_bus.right_phase;
               hsum_in    = SUM_W'(req_bus.left_height) + SUM_W'(req_bus.right_height);
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = mul_a * mul_b;
            if (!moving_ff) begin
               state_in = ST_FIN;
            end else if (peak_ff == '0) begin
               state_in = ST_ROUND;
            end else if (peak_ff < 0) begin
               held_in  = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV_SETUP;
            end
         end
         ST_ROUND: begin
            // Round to nearest, ties up; the value always fits in 32 bits
            held_in  = {{(SPEED_W - PROD_W + 8){rounded[PROD_W-1]}}, rounded[PROD_W-1:8]};
            state_in = ST_FIN;
         end
         ST_DIV_SETUP: begin
            // Numerator gain*peak*512 plus half the denominator for rounding
            den_in   = den_calc;
            num_in   = {1'b0, prod_ff[30:0], 9'b0} + {8'b0, den_calc[DEN_W-1:1]};
            rem_in   = '0;
            cnt_in   = CNT_W'(DIV_BITS);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One restoring step: shift in a numerator bit, try subtract
            rem_in = qbit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_in = {num_ff[DIV_BITS-2:0], qbit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               // Quotient stays below 2^24, no saturation reachable
               held_in  = $signed({num_ff[SPEED_W-2:0], qbit});
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold until the output register is free, then advance
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = held_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Configuration writes must arrive only while idle; the block does not enforce it
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SPEED_GAIN:    gain_in    = csr_bus.data;
            CSR_STILL_TIMEOUT: timeout_in = csr_bus.data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         prev_lp_ff   <= '0;
         prev_rp_ff   <= '0;
         lot_ff       <= '0;
         lct_ff       <= '0;
         rot_ff       <= '0;
         rct_ff       <= '0;
         flags_ff     <= '0;
         period_ff    <= '0;
         peak_ff      <= '0;
         still_ff     <= '0;
         held_ff      <= '0;
         moving_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         timeout_ff   <= timeout_in;
         prev_lp_ff   <= prev_lp_in;
         prev_rp_ff   <= prev_rp_in;
         lot_ff       <= lot_in;
         lct_ff       <= lct_in;
         rot_ff       <= rot_in;
         rct_ff       <= rct_in;
         flags_ff     <= flags_in;
         period_ff    <= period_in;
         peak_ff      <= peak_in;
         still_ff     <= still_in;
         held_ff      <= held_in;
         moving_ff    <= moving_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hsum_ff      <= hsum_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      rsp_speed_ff <= rsp_speed_in;
   end

endmodule
